/* rtl/core/tkst_pkg.sv */
// Shared types and function codes for the top-k score table.
package tkst_pkg;

  typedef enum logic [1:0] {
    FUNC_POST  = 2'd0,
    FUNC_FIND  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [63:0]        name_key;
    logic signed [31:0] score;
  } entry_t;

  typedef struct packed {
    func_t              func;
    logic [63:0]        name_key;
    logic signed [31:0] score;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic grow;
  } done_t;

endpackage

/* rtl/core/tkst_mem.sv */
// Entry memory: one write port, one read port, registered read data.
module tkst_mem #(
  parameter int TABLE_DEPTH = 10,
  parameter int AW = 4
) (
  input  logic            clk,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output tkst_pkg::entry_t rdata,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tkst_pkg::entry_t wdata
);
  import tkst_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/tkst_seq.sv */
// Scan sequencer: walks the entry memory for ripple insertion and lookup.
module tkst_seq #(
  parameter int TABLE_DEPTH = 10,
  parameter int AW = 4,
  parameter int CW = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tkst_pkg::cmd_t   cmd,
  input  logic [CW-1:0]    count,
  output logic             idle,
  output tkst_pkg::done_t  done,
  output logic [AW-1:0]    pos,
  input  logic             done_ready,
  output logic             re,
  output logic [AW-1:0]    raddr,
  input  tkst_pkg::entry_t rdata,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output tkst_pkg::entry_t wdata
);
  import tkst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_t;

  state_t             state;
  func_t              op;
  logic [63:0]        key;
  logic signed [31:0] sc;
  entry_t             carry;
  logic               inserted;
  logic               hit;
  logic               grow;
  logic [CW-1:0]      idx;

  logic [CW-1:0] idx_inc;
  logic          last;
  logic          ins_here;
  logic          match;
  logic          room;

  assign idx_inc  = idx + CW'(1);
  assign last     = (idx_inc == count);
  assign ins_here = !inserted && (rdata.score < sc);
  assign match    = (rdata.name_key == key) && (rdata.score == sc);
  assign room     = (count < CW'(TABLE_DEPTH));

  assign idle       = (state == S_IDLE);
  assign done.valid = (state == S_DONE);
  assign done.hit   = hit;
  assign done.grow  = grow;

  // Read one row ahead of the row under test; on a post, write back the carried entry.
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = carry;
    case (state)
      S_IDLE: begin
        re = start;
      end
      S_SCAN: begin
        if (!last) begin
          re    = 1'b1;
          raddr = idx_inc[AW-1:0];
        end
        we = (op == FUNC_POST) && (inserted || ins_here);
      end
      S_TAIL: begin
        if (room) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      inserted <= 1'b0;
      hit      <= 1'b0;
      grow     <= 1'b0;
      idx      <= '0;
      pos      <= '0;
      op       <= FUNC_NONE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op       <= cmd.func;
            key      <= cmd.name_key;
            sc       <= cmd.score;
            carry    <= '{name_key: cmd.name_key, score: cmd.score};
            inserted <= 1'b0;
            hit      <= 1'b0;
            grow     <= 1'b0;
            pos      <= '0;
            idx      <= '0;
            case (cmd.func)
              FUNC_POST: state <= (count == '0) ? S_TAIL : S_SCAN;
              FUNC_FIND: state <= (count == '0) ? S_DONE : S_SCAN;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (op == FUNC_FIND) begin
            if (match) begin
              hit   <= 1'b1;
              pos   <= idx[AW-1:0];
              state <= S_DONE;
            end else if (last) begin
              state <= S_DONE;
            end else begin
              idx <= idx_inc;
            end
          end else begin
            if (inserted || ins_here) begin
              carry <= rdata;
            end
            if (ins_here) begin
              inserted <= 1'b1;
              pos      <= idx[AW-1:0];
            end
            if (last) begin
              state <= S_TAIL;
            end else begin
              idx <= idx_inc;
            end
          end
        end
        S_TAIL: begin
          if (room) begin
            hit  <= 1'b1;
            grow <= 1'b1;
            if (!inserted) begin
              pos <= count[AW-1:0];
            end
          end else begin
            hit <= inserted;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/top_k_score_table.sv */
// Top level of the top-k score table: handshake, count and best, result register.
//
// Keeps up to TABLE_DEPTH name/score entries in one memory, sorted by descending
// score (ties keep arrival order). One word is taken at a time. A post walks the
// stored rows once, one row per cycle, carrying the displaced entry down the table
// (read row i+1 while writing row i), and then writes the tail row if the table has
// room. A find walks rows until the first match. A clear or an unused code walks no
// rows. A finished result sits in the output register, so the next word is taken
// while the last result still waits; the sequencer holds a new result until that
// register is free. Row and count are reported modulo 16.
module top_k_score_table #(
  parameter int TABLE_DEPTH = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [63:0]        name_key,
  input  logic signed [31:0] score,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [3:0]         row,
  output logic [3:0]         count,
  output logic signed [31:0] best
);
  import tkst_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = (AW > 4) ? AW : 4;
  localparam int NW = (CW > 4) ? CW : 4;

  // Table state kept outside the memory.
  logic [CW-1:0]      entry_count;
  logic signed [31:0] best_score;

  logic          accept;
  cmd_t          cmd;
  logic          seq_idle;
  done_t         done;
  logic [AW-1:0] pos;
  logic          done_ready;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic [CW-1:0] count_next;
  logic [RW-1:0] row_x;
  logic [NW-1:0] count_x;

  assign in_ready   = seq_idle;
  assign accept     = in_valid && in_ready;
  assign cmd.func   = func_t'(func);
  assign cmd.name_key = name_key;
  assign cmd.score  = score;

  // The result register is free when empty or being drained this cycle.
  assign done_ready = !out_valid || out_ready;
  assign count_next = done.grow ? entry_count + CW'(1) : entry_count;
  assign row_x      = RW'(pos);
  assign count_x    = NW'(count_next);

  tkst_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_mem (
    .clk  (clk),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata)
  );

  tkst_seq #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW),
    .CW(CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .cmd       (cmd),
    .count     (entry_count),
    .idle      (seq_idle),
    .done      (done),
    .pos       (pos),
    .done_ready(done_ready),
    .re        (mem_re),
    .raddr     (mem_raddr),
    .rdata     (mem_rdata),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      best_score  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Raise the best and apply a clear as the word is taken; the sequencer
      // never reads the count of a clear.
      if (accept) begin
        if (cmd.func == FUNC_POST && score > best_score) begin
          best_score <= score;
        end
        if (cmd.func == FUNC_CLEAR) begin
          best_score  <= '0;
          entry_count <= '0;
        end
      end
      // Load the result register; advance the count on a post that grew.
      if (done.valid && done_ready) begin
        out_valid   <= 1'b1;
        entry_count <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next result loads.
  always_ff @(posedge clk) begin
    if (done.valid && done_ready) begin
      hit   <= done.hit;
      row   <= row_x[3:0];
      count <= count_x[3:0];
      best  <= best_score;
    end
  end

endmodule

/* dv/top_k_score_table_tb.sv */
// Self-checking testbench for the top-k score table: directed and random words scored in order.
module top_k_score_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tkst_pkg::*;

  localparam int DEPTH     = 10;
  localparam int SHOW_MAX  = 10;
  // Wait after the last reply, well beyond the time any post takes.
  localparam int SETTLE    = 32;
  localparam int WAIT_MAX  = 20000;

  // One result word as the block reports it.
  typedef struct {
    logic               hit;
    logic [3:0]         row;
    logic [3:0]         count;
    logic signed [31:0] best;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  func_t              func = FUNC_NONE;
  logic [63:0]        name_key = '0;
  logic signed [31:0] score = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [3:0]         row;
  logic [3:0]         count;
  logic signed [31:0] best;

  // Shadow copy of the ranked entries, the fill level and the personal best.
  entry_t             ranked[DEPTH];
  int                 held = 0;
  logic signed [31:0] top_best = '0;

  // Replies owed by the block, oldest first.
  reply_t             replies_due[$];
  int unsigned        faults = 0;

  // Idle controls shared by the sender, the receiver and the test tasks.
  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;
  int unsigned        rx_hold = 0;

  top_k_score_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .name_key  (name_key),
    .score     (score),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .row       (row),
    .count     (count),
    .best      (best)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: stop a hung run long after the slowest correct one would finish.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Apply one accepted word to the shadow ranking and return the reply it owes.
  function automatic reply_t rank_update(func_t f, logic [63:0] key, logic signed [31:0] sc);
    reply_t r;
    int     pos;
    int     last;
    r.hit = 1'b0;
    r.row = 4'd0;
    case (f)
      FUNC_POST: begin
        // Skip every stored entry scoring at or above the new one, so ties keep order.
        pos = 0;
        while (pos < held && ranked[pos].score >= sc) pos++;
        if (pos < DEPTH) begin
          // Shift the tail down one row; on a full table the lowest row falls off.
          last = (held < DEPTH) ? held : DEPTH - 1;
          for (int i = last; i > pos; i--) ranked[i] = ranked[i - 1];
          ranked[pos].name_key = key;
          ranked[pos].score    = sc;
          if (held < DEPTH) held++;
          r.hit = 1'b1;
          r.row = pos[3:0];
        end
        if (sc > top_best) top_best = sc;
      end
      FUNC_FIND: begin
        for (int i = 0; i < held; i++) begin
          if (ranked[i].name_key == key && ranked[i].score == sc) begin
            r.hit = 1'b1;
            r.row = i[3:0];
            break;
          end
        end
      end
      FUNC_CLEAR: begin
        held     = 0;
        top_best = '0;
      end
      default: ;
    endcase
    r.count = held[3:0];
    r.best  = top_best;
    return r;
  endfunction

  task automatic flag_fault(string msg);
    faults++;
    if (faults <= SHOW_MAX) $display("%t: %s", $realtime, msg);
  endtask

  // Append one owed reply at the tail of the queue.
  task automatic book_reply(reply_t r);
    replies_due.insert(replies_due.size(), r);
  endtask

  // Offer one word after a random gap, hold it until taken, then book its reply.
  task automatic send_word(func_t f, logic [63:0] key, logic signed [31:0] sc);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(6);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= f;
    name_key <= key;
    score    <= sc;
    do @(posedge clk); while (in_ready !== 1'b1);
    book_reply(rank_update(f, key, sc));
  endtask

  // Drop valid and wait, bounded, until every owed reply is back.
  task automatic settle_replies();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due.size() != 0 && guard < WAIT_MAX) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Build one random word: mostly posts and finds aimed at stored rows, some noise.
  task automatic send_random_word();
    int unsigned pick;
    int unsigned mode;
    int unsigned k;
    logic [63:0]        key;
    logic signed [31:0] sc;
    pick = $urandom_range(99);
    mode = $urandom_range(3);
    key  = ($urandom_range(3) == 0) ? 64'($urandom_range(3)) : {$urandom, $urandom};
    case (mode)
      0: sc = $urandom;
      1: sc = $signed(32'($urandom_range(20))) - 32'sd10;
      2: sc = (held > 0) ? ranked[$urandom_range(held - 1)].score : $urandom;
      default: begin
        case ($urandom_range(3))
          0: sc = 32'sh7fff_ffff;
          1: sc = 32'sh8000_0000;
          2: sc = 32'sd0;
          default: sc = -32'sd1;
        endcase
      end
    endcase
    if (pick < 55) begin
      send_word(FUNC_POST, key, sc);
    end else if (pick < 92) begin
      // Aim most finds at a stored row, some at near misses.
      if (held > 0 && pick < 82) begin
        k   = $urandom_range(held - 1);
        key = ranked[k].name_key;
        if (pick < 74) sc = ranked[k].score;
        else sc = ranked[k].score + 32'sd1;
      end
      send_word(FUNC_FIND, key, sc);
    end else if (pick < 94) begin
      send_word(FUNC_CLEAR, key, sc);
    end else begin
      send_word(FUNC_NONE, key, sc);
    end
  endtask

  // Find on an empty table, the unused code, clear, and score extremes.
  task automatic test_empty_and_codes();
    send_word(FUNC_FIND, '0, '0);
    send_word(FUNC_NONE, '1, 32'sh8000_0000);
    send_word(FUNC_CLEAR, '1, 32'sh7fff_ffff);
    send_word(FUNC_POST, '1, 32'sh7fff_ffff);
    send_word(FUNC_POST, '0, 32'sh8000_0000);
    send_word(FUNC_FIND, '1, 32'sh7fff_ffff);
    send_word(FUNC_NONE, 64'h5555_aaaa_5555_aaaa, 32'sh5555_aaaa);
    send_word(FUNC_CLEAR, '0, '0);
  endtask

  // Equal scores keep arrival order; a negative post leaves the best at zero.
  task automatic test_order_and_ties();
    send_word(FUNC_POST, 64'hA, 32'sd0);
    send_word(FUNC_POST, 64'hB, 32'sd0);
    send_word(FUNC_POST, 64'hC, -32'sd5);
    send_word(FUNC_FIND, 64'hB, 32'sd0);
    send_word(FUNC_FIND, 64'hB, 32'sd1);
    send_word(FUNC_FIND, 64'hD, 32'sd0);
  endtask

  // Fill the table, then post level with and below the lowest row, then above it.
  task automatic test_full_table();
    for (int i = 0; i < 7; i++) send_word(FUNC_POST, 64'(16 + i), 32'(10 * (i + 1)));
    send_word(FUNC_POST, 64'hE, -32'sd5);
    send_word(FUNC_POST, 64'hF, -32'sd1000);
    send_word(FUNC_POST, 64'h10, 32'sd1);
    send_word(FUNC_FIND, 64'hC, -32'sd5);
  endtask

  // Hold the receiver off for a long stretch while words keep coming back to back.
  task automatic test_backpressure();
    rx_hold  = 60;
    tx_quiet = 1'b1;
    repeat (40) send_random_word();
    tx_quiet = 1'b0;
  endtask

  // Pause the sender until every reply is back, then resume.
  task automatic test_drain_pause();
    repeat (10) send_random_word();
    settle_replies();
    repeat (SETTLE) @(posedge clk);
    repeat (10) send_random_word();
  endtask

  // Random words in blocks; some blocks run with no idling on one or both sides.
  task automatic test_random(int unsigned words);
    for (int unsigned n = 0; n < words; n++) begin
      if (n % 100 == 0) begin
        tx_quiet = ($urandom_range(3) == 0);
        rx_quiet = ($urandom_range(3) == 0);
      end
      send_random_word();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Receiver: stall a random number of cycles per word, or the long hold when asked.
  initial begin : receiver
    int unsigned stall;
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(6);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
    end
  end

  // Scoreboard: compare each taken result with the oldest owed reply, field by field.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (replies_due.size() == 0) begin
        flag_fault($sformatf("unexpected result hit=%0b row=%0d count=%0d best=%0d",
                             hit, row, count, best));
      end else begin
        want = replies_due.pop_front();
        if (hit !== want.hit)
          flag_fault($sformatf("hit: expected %0b, got %0b", want.hit, hit));
        if (row !== want.row)
          flag_fault($sformatf("row: expected %0d, got %0d", want.row, row));
        if (count !== want.count)
          flag_fault($sformatf("count: expected %0d, got %0d", want.count, count));
        if (best !== want.best)
          flag_fault($sformatf("best: expected %0d, got %0d", want.best, best));
      end
    end
  end

  initial begin
    // Hold reset from time zero, release on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_codes();
    test_order_and_ties();
    test_full_table();
    test_backpressure();
    test_drain_pause();
    test_random(1120);

    // Wait for the last replies, then leave room for any stray result.
    settle_replies();
    repeat (SETTLE) @(posedge clk);
    if (replies_due.size() != 0)
      flag_fault($sformatf("%0d results never arrived", replies_due.size()));

    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
